@@ rtl/fsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsfc_pkg
// Widths, register indexes and limits shared by the frame clock files.
// ----------------------------------------------------------------------------
package fsfc_pkg;

  localparam int SCALE_FRAC_BITS = 16;

  localparam int FRAC_W   = SCALE_FRAC_BITS;
  localparam int LEN_W    = 24;
  localparam int SPEED_W  = 23;
  localparam int RD_W     = 32;
  localparam int DBG_W    = 16;
  localparam int SCALED_W = RD_W + SPEED_W;
  localparam int PROD_W   = RD_W + LEN_W;
  localparam int DTIME_W  = DBG_W + LEN_W + FRAC_W;
  localparam int DELTA_W  = 57;
  localparam int CARRY_W  = LEN_W + FRAC_W;
  localparam int TOTAL_W  = ((SCALED_W > CARRY_W) ? SCALED_W : CARRY_W) + 1;
  localparam int DVD_W    = TOTAL_W - FRAC_W;
  localparam int COUNT_W  = 40;
  localparam int RES_W    = 40;
  localparam int SUM_W    = 64;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FACTOR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HALTED       = CFG_IDX_W'(2);

  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic [LEN_W-1:0]   STEP_LENGTH_RST = LEN_W'(16667);
  localparam logic [SPEED_W-1:0] SPEED_RST       = SPEED_W'(64'd1 << FRAC_W);
  localparam logic [SPEED_W-1:0] SPEED_LIMIT     = SPEED_W'(64'd100 << FRAC_W);

  typedef struct packed {
    logic [DELTA_W-1:0] frame_delta;
    logic [SUM_W-1:0]   sim_elapsed;
    logic [SUM_W-1:0]   real_total;
    logic [COUNT_W-1:0] steps_due;
    logic [SUM_W-1:0]   frame_number;
    logic [SUM_W-1:0]   fixed_number;
    logic [RES_W-1:0]   residue;
    logic               was_halted;
    logic               debug_flag;
  } result_t;

endpackage

@@ rtl/fsfc_if.sv @@
// ----------------------------------------------------------------------------
// fsfc_if
// Valid/ready channels for frame clock request and result items.
// ----------------------------------------------------------------------------
interface fsfc_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [fsfc_pkg::RD_W-1:0]  real_delta;
  logic [fsfc_pkg::DBG_W-1:0] debug_steps;

  modport source (output valid, output op, output real_delta, output debug_steps,
                  input ready);
  modport sink (input valid, input op, input real_delta, input debug_steps,
                output ready);
endinterface

interface fsfc_out_if;
  logic                         valid;
  logic                         ready;
  logic [fsfc_pkg::DELTA_W-1:0] frame_delta;
  logic [fsfc_pkg::SUM_W-1:0]   sim_elapsed;
  logic [fsfc_pkg::SUM_W-1:0]   real_total;
  logic [fsfc_pkg::COUNT_W-1:0] steps_due;
  logic [fsfc_pkg::SUM_W-1:0]   frame_number;
  logic [fsfc_pkg::SUM_W-1:0]   fixed_number;
  logic [fsfc_pkg::RES_W-1:0]   residue;
  logic                         was_halted;
  logic                         debug_flag;

  modport source (output valid, output frame_delta, output sim_elapsed,
                  output real_total, output steps_due, output frame_number,
                  output fixed_number, output residue, output was_halted,
                  output debug_flag, input ready);
  modport sink (input valid, input frame_delta, input sim_elapsed,
                input real_total, input steps_due, input frame_number,
                input fixed_number, input residue, input was_halted,
                input debug_flag, output ready);
endinterface

@@ rtl/fsfc_divider.sv @@
// ----------------------------------------------------------------------------
// fsfc_divider
// Restoring divider, one quotient bit per cycle, for the whole step count.
// ----------------------------------------------------------------------------
module fsfc_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fsfc_pkg::DVD_W-1:0] dividend,
  input  logic [fsfc_pkg::LEN_W-1:0] divisor,
  output logic [fsfc_pkg::DVD_W-1:0] quotient,
  output logic [fsfc_pkg::LEN_W-1:0] remainder,
  output logic                       done
);

  localparam int CNT_W = $clog2(fsfc_pkg::DVD_W);

  logic [fsfc_pkg::DVD_W-1:0] dvd_r;
  logic [fsfc_pkg::LEN_W-1:0] rem_r;
  logic [fsfc_pkg::LEN_W-1:0] div_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       busy_r;
  logic                       done_r;

  logic [fsfc_pkg::LEN_W:0]   shifted;
  logic [fsfc_pkg::LEN_W:0]   diff;
  logic                       fits;

  assign shifted = {rem_r, dvd_r[fsfc_pkg::DVD_W-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign fits    = shifted >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? diff[fsfc_pkg::LEN_W-1:0] : shifted[fsfc_pkg::LEN_W-1:0];
        dvd_r <= {dvd_r[fsfc_pkg::DVD_W-2:0], fits};
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(fsfc_pkg::DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = dvd_r;
  assign remainder = rem_r;
  assign done      = done_r;

endmodule

@@ rtl/fixed_step_frame_clock.sv @@
// ----------------------------------------------------------------------------
// fixed_step_frame_clock
// Frame clock with a fixed-step accumulator and scaled simulation time.
// ----------------------------------------------------------------------------
// An advance item passes from acceptance through the shared 32x24 multiplier
// (scaled time in S_MUL1, then debug time in S_MUL2), the sums in S_ADD, the
// one-bit-per-cycle step divider in S_DIV (40 quotient bits, then its done
// flag) and S_FIN, which registers the result once the output can take it.
// A clear item goes straight to S_FIN. One item is in work at a time; the
// next is taken as soon as the result register is loaded, even while that
// result still waits on the output.
module fixed_step_frame_clock (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fsfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fsfc_pkg::CFG_DATA_W-1:0] cfg_data,
  fsfc_in_if.sink                         in_ch,
  fsfc_out_if.source                      out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_DIV,
    S_FIN
  } state_t;

  state_t state_r;

  logic [fsfc_pkg::LEN_W-1:0]   step_length_r;
  logic [fsfc_pkg::SPEED_W-1:0] speed_r;
  logic                         halted_r;

  logic [fsfc_pkg::SUM_W-1:0]   real_sum_r;
  logic [fsfc_pkg::SUM_W-1:0]   sim_sum_r;
  logic [fsfc_pkg::CARRY_W-1:0] carry_r;
  logic [fsfc_pkg::SUM_W-1:0]   frame_r;
  logic [fsfc_pkg::SUM_W-1:0]   fixed_r;

  logic                         clear_r;
  logic [fsfc_pkg::RD_W-1:0]    rd_r;
  logic [fsfc_pkg::DBG_W-1:0]   dbg_r;
  logic [fsfc_pkg::LEN_W-1:0]   len_r;
  logic [fsfc_pkg::SCALED_W-1:0] scaled_r;
  logic [fsfc_pkg::DTIME_W-1:0] dtime_r;
  logic [fsfc_pkg::DELTA_W-1:0] delta_r;
  logic [fsfc_pkg::FRAC_W-1:0]  total_lo_r;

  fsfc_pkg::result_t            res_r;
  logic                         out_valid_r;

  logic [fsfc_pkg::LEN_W-1:0]   len_eff;
  logic [fsfc_pkg::SPEED_W-1:0] speed_wr;
  logic [fsfc_pkg::RD_W-1:0]    mul_a;
  logic [fsfc_pkg::LEN_W-1:0]   mul_b;
  logic [fsfc_pkg::PROD_W-1:0]  prod;
  logic [fsfc_pkg::DELTA_W-1:0] delta_sum;
  logic [fsfc_pkg::TOTAL_W-1:0] total_sum;
  logic                         in_acc;
  logic                         res_load;

  logic                         div_start;
  logic [fsfc_pkg::DVD_W-1:0]   div_q;
  logic [fsfc_pkg::LEN_W-1:0]   div_rem;
  logic                         div_done;
  logic [fsfc_pkg::COUNT_W-1:0] count;

  // zero step length runs as one microsecond
  assign len_eff  = (step_length_r == '0) ? fsfc_pkg::LEN_W'(1) : step_length_r;
  assign speed_wr = (cfg_data[fsfc_pkg::SPEED_W-1:0] > fsfc_pkg::SPEED_LIMIT) ?
                    fsfc_pkg::SPEED_LIMIT : cfg_data[fsfc_pkg::SPEED_W-1:0];

  // shared multiplier: scaled time first, then debug steps times step length
  always_comb begin
    mul_a = rd_r;
    mul_b = fsfc_pkg::LEN_W'(speed_r);
    if (state_r == S_MUL2) begin
      mul_a = fsfc_pkg::RD_W'(dbg_r);
      mul_b = len_r;
    end
  end
  assign prod = fsfc_pkg::PROD_W'(mul_a) * fsfc_pkg::PROD_W'(mul_b);

  assign delta_sum = fsfc_pkg::DELTA_W'(scaled_r) + fsfc_pkg::DELTA_W'(dtime_r);
  assign total_sum = fsfc_pkg::TOTAL_W'(carry_r) + fsfc_pkg::TOTAL_W'(scaled_r);
  assign div_start = (state_r == S_ADD);
  assign count     = fsfc_pkg::COUNT_W'(div_q) + fsfc_pkg::COUNT_W'(dbg_r);

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign res_load = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  fsfc_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (total_sum[fsfc_pkg::TOTAL_W-1:fsfc_pkg::FRAC_W]),
    .divisor   (len_r),
    .quotient  (div_q),
    .remainder (div_rem),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      step_length_r <= fsfc_pkg::STEP_LENGTH_RST;
      speed_r       <= fsfc_pkg::SPEED_RST;
      halted_r      <= 1'b0;
      real_sum_r    <= '0;
      sim_sum_r     <= '0;
      carry_r       <= '0;
      frame_r       <= '0;
      fixed_r       <= '0;
      clear_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          fsfc_pkg::CFG_STEP_LENGTH:  step_length_r <= cfg_data[fsfc_pkg::LEN_W-1:0];
          fsfc_pkg::CFG_SPEED_FACTOR: speed_r <= speed_wr;
          fsfc_pkg::CFG_HALTED:       halted_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ch.ready && !res_load) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            rd_r    <= in_ch.real_delta;
            dbg_r   <= in_ch.debug_steps;
            len_r   <= len_eff;
            clear_r <= (in_ch.op == fsfc_pkg::OP_CLEAR);
            state_r <= (in_ch.op == fsfc_pkg::OP_CLEAR) ? S_FIN : S_MUL1;
          end
        end
        S_MUL1: begin
          scaled_r <= halted_r ? '0 : prod[fsfc_pkg::SCALED_W-1:0];
          state_r  <= S_MUL2;
        end
        S_MUL2: begin
          dtime_r <= fsfc_pkg::DTIME_W'(prod[fsfc_pkg::DBG_W+fsfc_pkg::LEN_W-1:0])
                     << fsfc_pkg::FRAC_W;
          state_r <= S_ADD;
        end
        S_ADD: begin
          delta_r    <= delta_sum;
          total_lo_r <= total_sum[fsfc_pkg::FRAC_W-1:0];
          sim_sum_r  <= sim_sum_r + fsfc_pkg::SUM_W'(delta_sum);
          real_sum_r <= real_sum_r + fsfc_pkg::SUM_W'(rd_r);
          state_r    <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (clear_r) begin
              res_r.frame_delta  <= '0;
              res_r.sim_elapsed  <= '0;
              res_r.real_total   <= '0;
              res_r.steps_due    <= '0;
              res_r.frame_number <= '0;
              res_r.fixed_number <= '0;
              res_r.residue      <= '0;
              res_r.was_halted   <= halted_r;
              res_r.debug_flag   <= 1'b0;
              real_sum_r         <= '0;
              sim_sum_r          <= '0;
              carry_r            <= '0;
              frame_r            <= '0;
              fixed_r            <= '0;
            end else begin
              res_r.frame_delta  <= delta_r;
              res_r.sim_elapsed  <= sim_sum_r;
              res_r.real_total   <= real_sum_r;
              res_r.steps_due    <= count;
              res_r.frame_number <= frame_r;
              res_r.fixed_number <= fixed_r;
              res_r.residue      <= fsfc_pkg::RES_W'({div_rem, total_lo_r});
              res_r.was_halted   <= halted_r;
              res_r.debug_flag   <= (dbg_r != '0);
              carry_r            <= {div_rem, total_lo_r};
              fixed_r            <= fixed_r + fsfc_pkg::SUM_W'(count);
              frame_r            <= frame_r + fsfc_pkg::SUM_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_delta  = res_r.frame_delta;
  assign out_ch.sim_elapsed  = res_r.sim_elapsed;
  assign out_ch.real_total   = res_r.real_total;
  assign out_ch.steps_due    = res_r.steps_due;
  assign out_ch.frame_number = res_r.frame_number;
  assign out_ch.fixed_number = res_r.fixed_number;
  assign out_ch.residue      = res_r.residue;
  assign out_ch.was_halted   = res_r.was_halted;
  assign out_ch.debug_flag   = res_r.debug_flag;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide state");

  a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
    speed_r <= fsfc_pkg::SPEED_LIMIT)
    else $error("speed factor above limit");

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && clear_r) |=> (real_sum_r == '0 && carry_r == '0 && frame_r == '0))
    else $error("clear item left running state");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |=> (out_valid_r && state_r == S_IDLE))
    else $error("loaded result not presented");

  a_frame_count: assert property (@(posedge clk) disable iff (!rst_n)
    (res_load && !clear_r) |=> (frame_r == $past(frame_r) + fsfc_pkg::SUM_W'(1)))
    else $error("frame index did not advance");
`endif

endmodule
